// ===== rtl/ibl_pkg.sv =====
// Shared types and constants for the image buffer layout calculator.
// Holds the request and result structs, format codes, layout classes and helpers.
// No dependencies.
`timescale 1ns / 1ps

package ibl_pkg;

  // Field widths
  localparam int DIM_BITS = 14;
  localparam int FMT_W    = 27;
  localparam int CS_W     = 3;
  localparam int OUT_W    = 30;
  localparam int LINES_W  = DIM_BITS + 1;
  localparam int PROD_W   = 2 * LINES_W;
  localparam int SIZE_W   = PROD_W + 3;

  // Shared-memory page size (power of two)
  localparam int PAGE_BYTES = 4096;

  // Number of valid color spaces
  localparam logic [CS_W-1:0] CS_COUNT = CS_W'(4);

  // Pixel format codes
  localparam logic [FMT_W-1:0] FMT_PLAIN      = 27'h0000000;
  localparam logic [FMT_W-1:0] FMT_UNSUP_A    = 27'h0010000;
  localparam logic [FMT_W-1:0] FMT_YV12       = 27'h0010001;
  localparam logic [FMT_W-1:0] FMT_NV_A       = 27'h0020000;
  localparam logic [FMT_W-1:0] FMT_NV_B       = 27'h0020001;
  localparam logic [FMT_W-1:0] FMT_P16_A      = 27'h0040000;
  localparam logic [FMT_W-1:0] FMT_P16_B      = 27'h0040001;
  localparam logic [FMT_W-1:0] FMT_Y8         = 27'h0080000;
  localparam logic [FMT_W-1:0] FMT_UNSUP_B    = 27'h0100000;
  localparam logic [FMT_W-1:0] FMT_SHM_LO     = 27'h0100001;
  localparam logic [FMT_W-1:0] FMT_SHM_HI     = 27'h0100003;
  localparam logic [FMT_W-1:0] FMT_UNSUP_C    = 27'h0800000;
  localparam logic [FMT_W-1:0] FMT_BLOB       = 27'h1000000;
  localparam logic [FMT_W-1:0] FMT_BLOB_HDR_A = 27'h1000001;
  localparam logic [FMT_W-1:0] FMT_BLOB_HDR_B = 27'h1000002;
  localparam logic [FMT_W-1:0] FMT_JPEG       = 27'h2000000;
  localparam logic [FMT_W-1:0] FMT_RGB3       = 27'h4000000;
  localparam logic [FMT_W-1:0] FMT_RGB_LO     = 27'h4000001;
  localparam logic [FMT_W-1:0] FMT_RGB_HI     = 27'h4000003;

  // Fixed sizes
  localparam logic [SIZE_W-1:0] BLOB_HDR_BYTES = SIZE_W'(32'h10000);
  localparam logic [SIZE_W-1:0] JPEG_BYTES     = SIZE_W'(32'h5001c);

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_INVALID     = 2'd1,
    ST_UNSUPPORTED = 2'd2
  } status_t;

  // Layout classes
  typedef enum logic [3:0] {
    CLS_BAD_ARG,
    CLS_UNSUPPORTED,
    CLS_PLAIN,
    CLS_YV12,
    CLS_NV,
    CLS_P16,
    CLS_Y8,
    CLS_BLOB,
    CLS_BLOB_HDR,
    CLS_JPEG,
    CLS_RGB3
  } fmt_class_t;

  // Decoder to datapath control
  typedef struct packed {
    fmt_class_t cls;
    logic       aligned;   // stride and lines are aligned
    logic       align16;   // stride aligned to 16 instead of 2
    logic       blob;      // size from raw w*h
    logic       shm;       // shared-memory pool rules
  } dec_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] frame_width;
    logic [DIM_BITS-1:0] frame_height;
    logic [FMT_W-1:0]    pixel_format;
    logic [CS_W-1:0]     cspace_idx;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [OUT_W-1:0]   line_stride;
    logic [LINES_W-1:0] plane_lines;
    logic [OUT_W-1:0]   buffer_bytes;
    logic [OUT_W-1:0]   first_plane_offset;
    logic [OUT_W-1:0]   second_plane_offset;
    logic [OUT_W-1:0]   image_bytes;
  } res_t;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // Clamp a wide value to the output field range
  function automatic logic [OUT_W-1:0] sat_out(input logic [SIZE_W-1:0] v);
    return (v > SIZE_W'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
  endfunction

endpackage

// ===== rtl/ibl_fmt_decode.sv =====
// Format decoder: maps a request and the pool kind to a layout class.
// Depends on ibl_pkg.
`timescale 1ns / 1ps

module ibl_fmt_decode
  import ibl_pkg::*;
(
  input  req_t req,
  input  logic shm,
  output dec_t dec
);

  fmt_class_t cls;
  logic       bad_arg;

  assign bad_arg = (req.cspace_idx >= CS_COUNT) ||
                   (req.frame_width == '0) || (req.frame_height == '0);

  // Class decode; argument checks win over the format code
  always_comb begin
    if (bad_arg) begin
      cls = CLS_BAD_ARG;
    end else begin
      unique case (req.pixel_format) inside
        FMT_PLAIN:                       cls = CLS_PLAIN;
        FMT_YV12:                        cls = CLS_YV12;
        FMT_NV_A, FMT_NV_B:              cls = CLS_NV;
        FMT_P16_A, FMT_P16_B:            cls = CLS_P16;
        FMT_Y8:                          cls = CLS_Y8;
        FMT_BLOB:                        cls = CLS_BLOB;
        FMT_BLOB_HDR_A, FMT_BLOB_HDR_B:  cls = CLS_BLOB_HDR;
        FMT_JPEG:                        cls = CLS_JPEG;
        FMT_RGB3:                        cls = CLS_RGB3;
        FMT_UNSUP_A, FMT_UNSUP_B, FMT_UNSUP_C,
        [FMT_RGB_LO:FMT_RGB_HI]:         cls = CLS_UNSUPPORTED;
        // unsupported in the shared-memory pool, invalid in the plain pool
        [FMT_SHM_LO:FMT_SHM_HI]:         cls = shm ? CLS_UNSUPPORTED : CLS_BAD_ARG;
        default:                         cls = CLS_BAD_ARG;
      endcase
    end
  end

  always_comb begin
    dec.cls     = cls;
    dec.aligned = (cls == CLS_YV12) || (cls == CLS_NV) || (cls == CLS_P16) ||
                  (cls == CLS_Y8) || (cls == CLS_RGB3);
    dec.align16 = (cls == CLS_YV12);
    dec.blob    = (cls == CLS_BLOB) || (cls == CLS_BLOB_HDR);
    dec.shm     = shm;
  end

endmodule

// ===== rtl/ibl_layout_core.sv =====
// Layout datapath: stride alignment, plane area multiply, size, offsets, rounding.
// Depends on ibl_pkg; driven by the class from ibl_fmt_decode.
`timescale 1ns / 1ps

module ibl_layout_core
  import ibl_pkg::*;
(
  input  req_t req,
  input  dec_t dec,
  output res_t res
);

  localparam logic [SIZE_W-1:0] PAGE_MASK = SIZE_W'(PAGE_BYTES - 1);

  logic [LINES_W-1:0]       w_x, h_x;
  logic [LINES_W-1:0]       w_up2, w_up16, h_up2;
  logic [DIM_BITS-1:0]      half_stride, chroma;
  logic [LINES_W-1:0]       stride_al;
  logic [LINES_W-1:0]       mul_a, mul_b;
  logic [PROD_W-1:0]        prod_area;
  logic [LINES_W+DIM_BITS-1:0] prod_chroma;
  logic [SIZE_W-1:0]        p, q, half_q;
  logic [SIZE_W-1:0]        size, stride, bytes, off1, off2, image;
  logic [LINES_W-1:0]       lines;
  status_t                  st;

  assign w_x = {1'b0, req.frame_width};
  assign h_x = {1'b0, req.frame_height};

  // Alignment to 2 and to 16
  assign w_up2  = {w_x[DIM_BITS:1] + DIM_BITS'(w_x[0]), 1'b0};
  assign h_up2  = {h_x[DIM_BITS:1] + DIM_BITS'(h_x[0]), 1'b0};
  assign w_up16 = {w_x[DIM_BITS:4] + (DIM_BITS-3)'(|w_x[3:0]), 4'b0};

  // Chroma stride: half the luma stride, aligned to 16
  assign half_stride = w_up16[DIM_BITS:1];
  assign chroma = {half_stride[DIM_BITS-1:4] + (DIM_BITS-4)'(|half_stride[3:0]), 4'b0};

  assign stride_al = dec.align16 ? w_up16 : w_up2;

  // Area multiply: aligned plane, or raw w*h for blob formats
  assign mul_a = dec.blob ? w_x : stride_al;
  assign mul_b = dec.blob ? h_x : h_up2;
  assign prod_area   = mul_a * mul_b;
  assign prod_chroma = h_up2 * chroma;

  assign p      = SIZE_W'(prod_area);
  assign q      = SIZE_W'(prod_chroma);
  assign half_q = q >> 1;

  // Total size, stride and lines per class
  always_comb begin
    size = SIZE_W'(w_x);
    case (dec.cls)
      CLS_YV12:     size = p + q;
      CLS_NV:       size = p + (p >> 1);
      CLS_P16:      size = p << 1;
      CLS_Y8:       size = p;
      CLS_BLOB:     size = p << 1;
      CLS_BLOB_HDR: size = (p << 1) + BLOB_HDR_BYTES;
      CLS_JPEG:     size = JPEG_BYTES;
      CLS_RGB3:     size = p + (p << 1);
      default:      size = SIZE_W'(w_x);
    endcase
  end

  always_comb begin
    if (dec.aligned) begin
      stride = SIZE_W'(stride_al);
      lines  = h_up2;
    end else if (dec.cls == CLS_JPEG || (dec.blob && !dec.shm)) begin
      stride = size;
      lines  = LINES_W'(1);
    end else begin
      stride = SIZE_W'(w_x);
      lines  = LINES_W'(1);
    end
  end

  // Page rounding for the shared pool
  assign bytes = dec.shm ? ((size + PAGE_MASK) & ~PAGE_MASK) : size;

  // Plane offsets and image size
  always_comb begin
    off1  = '0;
    off2  = '0;
    image = bytes;
    case (dec.cls)
      CLS_NV: begin
        off1  = p;
        image = p + (p >> 1);
      end
      CLS_YV12: begin
        off2  = p;
        off1  = p + half_q;
        image = p + half_q + half_q;
      end
      CLS_P16: begin
        off1  = p;
        image = p << 1;
      end
      CLS_Y8:  image = p;
      default: image = bytes;
    endcase
  end

  always_comb begin
    case (dec.cls)
      CLS_BAD_ARG:     st = ST_INVALID;
      CLS_UNSUPPORTED: st = ST_UNSUPPORTED;
      default:         st = ST_OK;
    endcase
  end

  // Failed transactions report status only
  always_comb begin
    res = '0;
    res.status = st;
    if (st == ST_OK) begin
      res.line_stride         = sat_out(stride);
      res.plane_lines         = lines;
      res.buffer_bytes        = sat_out(bytes);
      res.first_plane_offset  = sat_out(off1);
      res.second_plane_offset = sat_out(off2);
      res.image_bytes         = sat_out(image);
    end
  end

endmodule

// ===== rtl/image_buffer_layout_calc_unit.sv =====
// Top level of the image buffer layout calculator: request and result registers,
// pool configuration register. Depends on ibl_pkg, ibl_fmt_decode, ibl_layout_core.
`timescale 1ns / 1ps

// Usage:
//   A request transaction (in_req: width, height, format code, color space) is
//   taken at a rising edge with start high and busy low. busy is low at all
//   times out of reset, so one request can be issued every cycle.
//   Each request yields exactly one result on out_res, marked by out_valid for
//   a single cycle; the request passes through the request register and then
//   the result register.
//   Throughput is one transaction per cycle; the path between the request
//   register and the result register is one format decode, two narrow
//   multipliers in parallel (plane area and chroma area), a size add, a
//   page-rounding add and the output clamp.
//   cfg_wr_en/cfg_wr_data write the pool kind (0 plain, 1 shared memory); it
//   is sampled with each request and should only change while no request is
//   in flight.
//   rst_n is synchronous and active low: it clears the pool kind to plain
//   memory and drops any request in flight; busy is high while rst_n is low.
//   The receiver cannot stall: a result is present for one cycle only.

module image_buffer_layout_calc_unit
  import ibl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_req,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  output logic out_valid,
  output res_t out_res
);

  logic pool_kind_r;
  logic req_valid_r, req_valid_nxt;
  req_t req_r;
  logic req_shm_r;
  logic out_valid_r;
  res_t out_res_r;
  dec_t dec;
  res_t res;

  assign busy          = ~rst_n;
  assign req_valid_nxt = start & ~busy;

  // Pool configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_kind_r <= 1'b0;
    end else if (cfg_wr_en) begin
      pool_kind_r <= cfg_wr_data;
    end
  end

  // Request stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid_nxt) begin
      req_r     <= in_req;
      req_shm_r <= pool_kind_r;
    end
  end

  ibl_fmt_decode u_decode (
    .req (req_r),
    .shm (req_shm_r),
    .dec (dec)
  );

  ibl_layout_core u_core (
    .req (req_r),
    .dec (dec),
    .res (res)
  );

  // Result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid_r) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== dv/image_buffer_layout_calc_unit_tb.sv =====
// Self-checking testbench for image_buffer_layout_calc_unit: directed and random
// layout requests in both pool kinds, each result checked field by field.
// Depends on ibl_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module image_buffer_layout_calc_unit_tb;
  import ibl_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int PIPE_DEPTH  = 2;       // request edge to result edge
  localparam int DRAIN_LIMIT = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_FMTS    = 18;

  logic clk         = 1'b0;
  logic rst_n       = 1'b0;
  logic start       = 1'b0;
  logic busy;
  req_t in_req      = '0;
  logic cfg_wr_en   = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic out_valid;
  res_t out_res;

  // Testbench copy of the pool kind register
  bit   pool_shm = 1'b0;
  res_t expected_layouts[$];
  int   fail_count    = 0;
  int   cycle_count   = 0;
  int   no_pause_left = 0;

  image_buffer_layout_calc_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_valid  (out_valid),
    .out_res    (out_res)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Layout prediction
  // ---------------------------------------------------------------------------
  function automatic longint unsigned align2(longint unsigned v);
    return (v + 1) & ~64'd1;
  endfunction

  function automatic longint unsigned align16(longint unsigned v);
    return (v + 15) & ~64'd15;
  endfunction

  function automatic logic [OUT_W-1:0] clamp_out(longint unsigned v);
    return (v > OUT_MAX) ? OUT_MAX : v[OUT_W-1:0];
  endfunction

  function automatic res_t predict_layout(req_t r, bit shm);
    longint unsigned w, h, sz, stride, lines, p, off1, off2, image, bytes, half;
    logic [FMT_W-1:0] f;
    res_t res;
    res    = '0;
    w      = r.frame_width;
    h      = r.frame_height;
    f      = r.pixel_format;
    if (r.cspace_idx >= CS_COUNT || w == 0 || h == 0) begin
      res.status = ST_INVALID;
      return res;
    end
    sz     = w;
    stride = w;
    lines  = 1;
    off1   = 0;
    off2   = 0;
    case (f)
      FMT_PLAIN: begin
        // stride w, one line, size w
      end
      FMT_YV12: begin
        stride = align16(w);
        lines  = align2(h);
        sz     = (align16(stride >> 1) + stride) * lines;
      end
      FMT_NV_A, FMT_NV_B: begin
        stride = align2(w);
        lines  = align2(h);
        p      = stride * lines;
        sz     = p + (p >> 1);
      end
      FMT_P16_A, FMT_P16_B: begin
        stride = align2(w);
        lines  = align2(h);
        sz     = stride * lines * 2;
      end
      FMT_Y8: begin
        stride = align2(w);
        lines  = align2(h);
        sz     = stride * lines;
      end
      FMT_BLOB, FMT_BLOB_HDR_A, FMT_BLOB_HDR_B: begin
        sz     = h * w * 2 + ((f == FMT_BLOB) ? 0 : BLOB_HDR_BYTES);
        stride = shm ? w : sz;
      end
      FMT_JPEG: begin
        sz     = JPEG_BYTES;
        stride = sz;
      end
      FMT_RGB3: begin
        stride = align2(w);
        lines  = align2(h);
        sz     = stride * lines * 3;
      end
      default: begin
        // shared pool also rejects the 0x100001..0x100003 family
        if (f == FMT_UNSUP_A || f == FMT_UNSUP_B || f == FMT_UNSUP_C ||
            (f >= FMT_RGB_LO && f <= FMT_RGB_HI) ||
            (shm && f >= FMT_SHM_LO && f <= FMT_SHM_HI))
          res.status = ST_UNSUPPORTED;
        else
          res.status = ST_INVALID;
        return res;
      end
    endcase

    bytes = shm ? ((sz + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES : sz;
    image = bytes;
    p     = stride * lines;
    case (f)
      FMT_NV_A, FMT_NV_B: begin
        off1  = p;
        image = p + (p >> 1);
      end
      FMT_YV12: begin
        half  = (lines * align16(stride >> 1)) >> 1;
        off2  = p;
        off1  = p + half;
        image = off1 + half;
      end
      FMT_P16_A, FMT_P16_B: begin
        off1  = p;
        image = p * 2;
      end
      FMT_Y8: image = p;
      default: begin
        // image size equals the reserved size
      end
    endcase

    res.status              = ST_OK;
    res.line_stride         = clamp_out(stride);
    res.plane_lines         = (lines > 64'h7FFF) ? '1 : lines[LINES_W-1:0];
    res.buffer_bytes        = clamp_out(bytes);
    res.first_plane_offset  = clamp_out(off1);
    res.second_plane_offset = clamp_out(off2);
    res.image_bytes         = clamp_out(image);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_layout(res_t got);
    res_t want;
    if (expected_layouts.size() == 0) begin
      $error("result transaction with no request outstanding");
      fail_count++;
      return;
    end
    want = expected_layouts.pop_front();
    check_field("status", want.status, got.status);
    check_field("line_stride", want.line_stride, got.line_stride);
    check_field("plane_lines", want.plane_lines, got.plane_lines);
    check_field("buffer_bytes", want.buffer_bytes, got.buffer_bytes);
    check_field("first_plane_offset", want.first_plane_offset, got.first_plane_offset);
    check_field("second_plane_offset", want.second_plane_offset, got.second_plane_offset);
    check_field("image_bytes", want.image_bytes, got.image_bytes);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        check_layout(out_res);
      end else if (out_valid !== 1'b0) begin
        $error("out_valid is unknown");
        fail_count++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  function automatic req_t make_req(int w, int h, logic [FMT_W-1:0] f, int cs);
    req_t r;
    r.frame_width  = DIM_BITS'(w);
    r.frame_height = DIM_BITS'(h);
    r.pixel_format = f;
    r.cspace_idx   = CS_W'(cs);
    return r;
  endfunction

  // Issue one request; start stays high so the next one can follow back to back
  task automatic send_req(req_t r);
    in_req <= r;
    start  <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    expected_layouts.push_back(predict_layout(r, pool_shm));
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Random spacing between requests: mostly short, a few long, some bursts
  task automatic random_pause();
    int sel;
    if (no_pause_left > 0) begin
      no_pause_left--;
      return;
    end
    sel = $urandom_range(0, 99);
    if (sel < 45)      return;
    else if (sel < 80) idle_cycles($urandom_range(1, 3));
    else if (sel < 93) idle_cycles($urandom_range(4, 12));
    else if (sel < 97) idle_cycles($urandom_range(20, 80));
    else               no_pause_left = $urandom_range(20, 60);
  endtask

  // Wait for every outstanding result, then let the pipeline settle
  task automatic drain_results();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (expected_layouts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_layouts.size() != 0) begin
      $error("%0d result transactions never arrived", expected_layouts.size());
      fail_count++;
      expected_layouts.delete();
    end
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_pool_kind(bit shm);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= shm;
    @(posedge clk);
    pool_shm    = shm;
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [FMT_W-1:0] known_format(int i);
    case (i)
      0:       return FMT_PLAIN;
      1:       return FMT_UNSUP_A;
      2:       return FMT_YV12;
      3:       return FMT_NV_A;
      4:       return FMT_NV_B;
      5:       return FMT_P16_A;
      6:       return FMT_P16_B;
      7:       return FMT_Y8;
      8:       return FMT_UNSUP_B;
      9:       return FMT_SHM_LO;
      10:      return FMT_SHM_HI;
      11:      return FMT_UNSUP_C;
      12:      return FMT_BLOB;
      13:      return FMT_BLOB_HDR_A;
      14:      return FMT_BLOB_HDR_B;
      15:      return FMT_JPEG;
      16:      return FMT_RGB3;
      default: return FMT_RGB_HI;
    endcase
  endfunction

  function automatic logic [DIM_BITS-1:0] rand_dim();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 3)       return '0;
    else if (sel < 43) return DIM_BITS'($urandom_range(1, 64));
    else if (sel < 53) return DIM_BITS'($urandom_range(16300, 16383));
    else               return DIM_BITS'($urandom_range(1, 16383));
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int   sel;
    r.frame_width  = rand_dim();
    r.frame_height = rand_dim();
    r.cspace_idx   = ($urandom_range(0, 19) == 0) ? CS_W'($urandom_range(4, 7))
                                                  : CS_W'($urandom_range(0, 3));
    sel = $urandom_range(0, 99);
    if (sel < 80)
      r.pixel_format = known_format($urandom_range(0, NUM_FMTS - 1));
    else if (sel < 90)  // near miss: one bit off a listed code
      r.pixel_format = known_format($urandom_range(0, NUM_FMTS - 1)) ^
                       (FMT_W'(1) << $urandom_range(0, FMT_W - 1));
    else
      r.pixel_format = FMT_W'($urandom);
    return r;
  endfunction

  // Zero sizes and out-of-range color spaces
  task automatic test_invalid_arguments();
    send_req(make_req(0, 16383, FMT_YV12, 0));
    send_req(make_req(16383, 0, FMT_NV_A, 3));
    send_req(make_req(0, 0, FMT_PLAIN, 7));
    send_req(make_req(640, 480, FMT_RGB3, 4));
  endtask

  // Each code from known_format and one unlisted code in the plain pool, dims at extremes
  task automatic test_plain_pool_formats();
    for (int i = 0; i < NUM_FMTS; i++) begin
      send_req(make_req(i[0] ? 16383 : 1, i[1] ? 16383 : 3, known_format(i), i % 4));
      if (i % 5 == 4) idle_cycles(i / 5 + 1);
    end
    send_req(make_req(17, 9, '1, 2));
  endtask

  // Codes whose handling depends on the shared pool
  task automatic test_shared_pool_formats();
    send_req(make_req(16383, 16383, FMT_BLOB, 0));
    send_req(make_req(1, 1, FMT_BLOB_HDR_B, 1));
    send_req(make_req(33, 7, FMT_SHM_LO, 2));
    send_req(make_req(33, 7, FMT_SHM_HI, 3));
    send_req(make_req(33, 7, FMT_UNSUP_B, 0));
    send_req(make_req(16383, 16383, FMT_RGB3, 1));
    send_req(make_req(1, 1, FMT_YV12, 2));
  endtask

  task automatic test_random_traffic(int n);
    for (int i = 0; i < n; i++) begin
      send_req(rand_req());
      random_pause();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_invalid_arguments();
    test_plain_pool_formats();
    write_pool_kind(1'b1);
    test_shared_pool_formats();

    write_pool_kind(1'b0);
    test_random_traffic(400);
    write_pool_kind(1'b1);
    test_random_traffic(400);
    write_pool_kind(1'b0);
    test_random_traffic(350);
    write_pool_kind(1'b1);
    test_random_traffic(350);

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
